// ===== hw/rtl/ptpn_pkg.sv =====
// ----------------------------------------------------------------------------
// ptpn_pkg
// Shared types, constants and helper functions for the pilot tone PLL/NCO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptpn_pkg;

  // data widths
  localparam int SAMPLE_BITS   = 16;
  localparam int SAMPLE_BYTES  = (SAMPLE_BITS + 7) / 8;
  localparam int TDATA_W       = SAMPLE_BYTES * 8;
  localparam int CORDIC_STEPS  = 18;
  localparam int TABLE_LEN     = 32;
  localparam int CNT_W         = $clog2(TABLE_LEN);
  localparam int MIX_SH        = 62 - 2 * SAMPLE_BITS;
  localparam int RND_SH        = 31 - SAMPLE_BITS;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  localparam logic [31:0]        HALF_TURN    = 32'h8000_0000;
  localparam logic signed [63:0] INV_GAIN_Q30 = 64'sd652032874;
  localparam logic signed [63:0] SMAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] SMIN = -(64'sd1 <<< (SAMPLE_BITS - 1));

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NCO_SCALE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_ADJUST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN      = 3'd4;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MIX,
    S_ATAN_GO,
    S_ATAN_RUN,
    S_KI,
    S_KP,
    S_TRIG,
    S_FB_GO,
    S_FB_RUN,
    S_OUT_GO,
    S_OUT_RUN
  } state_t;

  // request to the shared cordic unit
  typedef struct packed {
    logic               start;
    logic               vec;     // 1: vectoring (atan2), 0: rotation (cos/sin)
    logic signed [63:0] x0;
    logic signed [63:0] y0;
    logic [31:0]        ang;
  } cordic_req_t;

  // status and results from the cordic unit
  typedef struct packed {
    logic                          busy;
    logic signed [SAMPLE_BITS-1:0] cos_s;
    logic signed [SAMPLE_BITS-1:0] sin_s;
    logic [31:0]                   angle;
  } cordic_rsp_t;

  // atan(2^-i) in 2^-32 turns
  function automatic logic [31:0] atan_turns(input logic [CNT_W-1:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;  5'd31: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // q1.30 to sample width, round half up, saturate
  function automatic logic signed [SAMPLE_BITS-1:0] to_sample(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
    if (r > SMAX) r = SMAX;
    if (r < SMIN) r = SMIN;
    return r[SAMPLE_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ptpn_cordic.sv =====
// ----------------------------------------------------------------------------
// ptpn_cordic
// Shared iterative CORDIC: vectoring for atan2, rotation for cos/sin.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptpn_cordic
  import ptpn_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  cordic_req_t req,
  output cordic_rsp_t rsp
);

  logic signed [63:0] x;
  logic signed [63:0] y;
  logic [31:0]        z;
  logic [CNT_W-1:0]   cnt;
  logic               vec;
  logic               flip;
  logic               busy;

  logic signed [63:0] xs;
  logic signed [63:0] ys;
  logic               up;
  logic [31:0]        start_ang;
  logic               start_flip;

  // per-step shifted terms and direction
  always_comb begin
    xs = x >>> cnt;
    ys = y >>> cnt;
    up = vec ? y[63] : ~z[31];
    start_flip = req.ang[31] ^ req.ang[30];
    start_ang  = start_flip ? req.ang + HALF_TURN : req.ang;
  end

  // iteration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      vec <= req.vec;
      cnt <= '0;
      if (req.vec) begin
        flip <= 1'b0;
        if (req.x0 == 64'sd0 && req.y0 == 64'sd0) begin
          // zero vector gives a zero angle
          x    <= '0;
          y    <= '0;
          z    <= '0;
          busy <= 1'b0;
        end else if (req.x0[63]) begin
          x    <= -req.x0;
          y    <= -req.y0;
          z    <= HALF_TURN;
          busy <= 1'b1;
        end else begin
          x    <= req.x0;
          y    <= req.y0;
          z    <= '0;
          busy <= 1'b1;
        end
      end else begin
        flip <= start_flip;
        x    <= INV_GAIN_Q30;
        y    <= '0;
        z    <= start_ang;
        busy <= 1'b1;
      end
    end else if (busy) begin
      if (up) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_turns(cnt);
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_turns(cnt);
      end
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // results, quadrant fold undone for rotation
  always_comb begin
    rsp.busy  = busy;
    rsp.cos_s = to_sample(flip ? -x : x);
    rsp.sin_s = to_sample(flip ? -y : y);
    rsp.angle = z;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pilot_tone_pll_nco_core.sv =====
// ----------------------------------------------------------------------------
// pilot_tone_pll_nco_core
// PLL on a real pilot tone with PI loop filter and scaled NCO output.
// ----------------------------------------------------------------------------
// One sample beat in gives one nco_out beat. The single CORDIC unit runs
// three passes per sample (phase detector atan2, feedback cos/sin, output
// cosine); the atan2 pass ends at once when both mixer products are zero.
// tready stays low from acceptance until the result is written into the
// output register. A result still waiting there holds the next sample in its
// last pass. Configuration writes are always taken and must be issued while
// the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module pilot_tone_pll_nco_core
  import ptpn_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire  [TDATA_W-1:0]    s_axis_tdata,   // sample
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  output logic [TDATA_W-1:0]    m_axis_tdata,   // nco_out
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [CFG_IDX_W-1:0]  cfg_index,
  input  wire  [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [31:0] phase_step;
  logic [15:0] nco_scale;
  logic [31:0] phase_adjust;
  logic [23:0] kp_gain;
  logic [23:0] ki_gain;

  // loop state
  logic [47:0] nco_phase;
  logic [47:0] phase_estimate;
  logic [47:0] loop_integrator;
  logic signed [SAMPLE_BITS-1:0] feedback_cos;
  logic signed [SAMPLE_BITS-1:0] feedback_sin;

  // per-sample working registers
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [63:0]            mix_i;
  logic signed [63:0]            mix_q;
  logic signed [31:0]            err;
  logic [47:0]                   trig;
  logic [55:0]                   scaled;
  logic [31:0]                   outang;
  logic signed [SAMPLE_BITS-1:0] nco_out;
  logic                          out_valid;

  state_t state, state_next;
  cordic_req_t req;
  cordic_rsp_t rsp;

  logic signed [2*SAMPLE_BITS-1:0] prod_i;
  logic signed [2*SAMPLE_BITS-1:0] prod_q;
  logic [23:0]                     gain;
  logic signed [56:0]              gain_prod;
  logic signed [56:0]              gain_rnd;
  logic [47:0]                     gain_term;
  logic                            in_beat;
  logic                            out_load;

  ptpn_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TDATA_W'($unsigned(nco_out));

  // mixer products and rounded gain product
  always_comb begin
    prod_i    = sample * feedback_cos;
    prod_q    = sample * feedback_sin;
    gain      = (state == S_KI) ? ki_gain : kp_gain;
    gain_prod = err * $signed({1'b0, gain});
    gain_rnd  = gain_prod + 57'sd8388608;
    gain_term = 48'(gain_rnd >>> 24);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.start  = 1'b0;
    req.vec    = 1'b0;
    req.x0     = mix_i;
    req.y0     = mix_q;
    req.ang    = trig[31:0];
    out_load   = 1'b0;
    unique case (state)
      S_IDLE:     if (in_beat) state_next = S_MIX;
      S_MIX:      state_next = S_ATAN_GO;
      S_ATAN_GO: begin
        req.start  = 1'b1;
        req.vec    = 1'b1;
        state_next = S_ATAN_RUN;
      end
      S_ATAN_RUN: if (!rsp.busy) state_next = S_KI;
      S_KI:       state_next = S_KP;
      S_KP:       state_next = S_TRIG;
      S_TRIG:     state_next = S_FB_GO;
      S_FB_GO: begin
        req.start  = 1'b1;
        state_next = S_FB_RUN;
      end
      S_FB_RUN:   if (!rsp.busy) state_next = S_OUT_GO;
      S_OUT_GO: begin
        req.start  = 1'b1;
        req.ang    = outang;
        state_next = S_OUT_RUN;
      end
      S_OUT_RUN: begin
        if (!rsp.busy && !out_valid) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= '0;
      nco_scale    <= 16'd256;
      phase_adjust <= '0;
      kp_gain      <= '0;
      ki_gain      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PHASE_STEP:   phase_step   <= cfg_data;
        REG_NCO_SCALE:    nco_scale    <= cfg_data[15:0];
        REG_PHASE_ADJUST: phase_adjust <= cfg_data;
        REG_KP_GAIN:      kp_gain      <= cfg_data[23:0];
        REG_KI_GAIN:      ki_gain      <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // loop state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      nco_phase       <= '0;
      phase_estimate  <= '0;
      loop_integrator <= '0;
      feedback_cos    <= SAMPLE_BITS'(SMAX);
      feedback_sin    <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (in_beat) begin
        sample <= s_axis_tdata[SAMPLE_BITS-1:0];
      end
      if (state == S_MIX) begin
        mix_i <= 64'(prod_i) <<< MIX_SH;
        mix_q <= -(64'(prod_q) <<< MIX_SH);
      end
      if (state == S_ATAN_RUN && !rsp.busy) begin
        err <= rsp.angle;
      end
      if (state == S_KI) begin
        loop_integrator <= loop_integrator + gain_term;
      end
      if (state == S_KP) begin
        phase_estimate <= phase_estimate + gain_term + loop_integrator;
      end
      if (state == S_TRIG) begin
        trig <= nco_phase + phase_estimate;
      end
      if (state == S_FB_GO) begin
        scaled <= trig[39:0] * nco_scale;
      end
      if (state == S_FB_RUN && !rsp.busy) begin
        feedback_cos <= rsp.cos_s;
        feedback_sin <= rsp.sin_s;
        outang       <= scaled[39:8] + phase_adjust;
      end
      // result beat held until taken
      if (out_load) begin
        nco_out   <= rsp.cos_s;
        out_valid <= 1'b1;
        nco_phase <= nco_phase + 48'(phase_step);
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ptpn_checker.sv =====
// ----------------------------------------------------------------------------
// ptpn_checker
// Port-level checks for the pilot tone PLL/NCO core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptpn_checker
  import ptpn_pkg::*;
(
  input wire                  clk,
  input wire                  rst,
  input wire                  s_axis_tvalid,
  input wire                  s_axis_tready,
  input wire                  m_axis_tvalid,
  input wire                  m_axis_tready,
  input wire [TDATA_W-1:0]    m_axis_tdata,
  input wire                  cfg_valid,
  input wire                  cfg_ready
);

  // no result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat right after reset");

  // a sample keeps the input closed while it is worked on
  a_busy_1: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a sample beat");

  a_busy_3: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> ##2 !s_axis_tready && !(m_axis_tvalid && $rose(m_axis_tvalid)))
    else $error("sample finished too early");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  // configuration is always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind pilot_tone_pll_nco_core ptpn_checker u_ptpn_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready)
);

`default_nettype wire

// ===== tb/pilot_tone_pll_nco_core_tb.sv =====
// ----------------------------------------------------------------------------
// pilot_tone_pll_nco_core_tb
// Drives sample beats through the pilot tone PLL/NCO and checks every nco_out
// beat against a bit-exact loop model kept in the bench. Directed table first,
// then random phases over several register settings and handshake mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pilot_tone_pll_nco_core_tb;
  import ptpn_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN    = 200;
  localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pilot_tone_pll_nco_core dut (.*);

  // bench copy of registers and loop state
  logic [31:0] m_step, m_adj;
  logic [15:0] m_scale;
  logic [23:0] m_kp, m_ki;
  logic [47:0] m_nco, m_est, m_integ;
  logic signed [63:0] m_fbc, m_fbs;

  logic signed [SAMPLE_BITS-1:0] nco_expected[$];
  int errors = 0;
  int idle_cycles = 0;
  int src_idle, snk_idle;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // arctangent table, 2^-32 turns
  function automatic logic [31:0] atan_step(int i);
    logic [31:0] t[32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000};
    return t[i];
  endfunction

  function automatic logic signed [63:0] round_sat(logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< (RND_SH - 1))) >>> RND_SH;
    if (r > SMAX) r = SMAX;
    if (r < SMIN) r = SMIN;
    return r;
  endfunction

  task automatic rotate(input logic [31:0] ang, output logic signed [63:0] c,
                        output logic signed [63:0] s);
    logic flip;
    logic signed [63:0] x, y, z, nx;
    flip = ang[31] ^ ang[30];
    if (flip) ang = ang + 32'h8000_0000;
    x = 64'sd652032874; y = 0;
    z = $signed({{32{ang[31]}}, ang});
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - atan_step(i);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + atan_step(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic signed [63:0] vector_angle(logic signed [63:0] y,
                                                       logic signed [63:0] x);
    logic [31:0] z;
    logic signed [63:0] nx;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + atan_step(i);
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - atan_step(i);
      end
      x = nx;
    end
    return $signed({{32{z[31]}}, z});
  endfunction

  function automatic logic [47:0] gain_product(logic signed [63:0] e, logic [23:0] g);
    logic signed [63:0] p;
    p = (e * $signed({40'd0, g}) + (64'sd1 <<< 23)) >>> 24;
    return p[47:0];
  endfunction

  // one loop update, returns the nco_out for this sample
  task automatic advance_loop(input logic [15:0] smp, output logic signed [15:0] res);
    logic signed [63:0] x, mi, mq, err, c, s;
    logic [47:0] trig;
    logic [63:0] prod;
    logic [31:0] oang;
    x = $signed({{48{smp[15]}}, smp});
    mi = (x * m_fbc) <<< MIX_SH;
    mq = (-(x * m_fbs)) <<< MIX_SH;
    err = vector_angle(mq, mi);
    m_integ = (m_integ + gain_product(err, m_ki)) & M48;
    m_est = (m_est + gain_product(err, m_kp) + m_integ) & M48;
    trig = (m_nco + m_est) & M48;
    rotate(trig[31:0], c, s);
    m_fbc = round_sat(c);
    m_fbs = round_sat(s);
    prod = {16'd0, trig} * {48'd0, m_scale};
    oang = (prod >> 8) + m_adj;
    rotate(oang, c, s);
    c = round_sat(c);
    res = c[15:0];
    m_nco = (m_nco + {16'd0, m_step}) & M48;
  endtask

  // receiver side with random stall and checking
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (nco_expected.size() == 0) begin
        $error("nco_out beat with nothing expected: %0d", $signed(m_axis_tdata[15:0]));
        errors++;
      end else begin
        logic signed [15:0] e;
        e = nco_expected.pop_front();
        if (m_axis_tdata[15:0] !== e) begin
          $error("nco_out expected %0d actual %0d", e, $signed(m_axis_tdata[15:0]));
          errors++;
        end
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one register write, valid dropped before the next write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PHASE_STEP:   m_step = val;
      REG_NCO_SCALE:    m_scale = val[15:0];
      REG_PHASE_ADJUST: m_adj = val;
      REG_KP_GAIN:      m_kp = val[23:0];
      REG_KI_GAIN:      m_ki = val[23:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // valid stays up after a beat until the next sample or a drain
  task automatic send_sample(input logic [15:0] smp);
    logic signed [15:0] r;
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1; s_axis_tdata <= smp;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    advance_loop(smp, r);
    nco_expected.push_back(r);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (nco_expected.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // directed rows: sample, then a known result or -1 to use the model
  typedef struct { logic [15:0] smp; int known; } row_t;
  row_t rows[] = '{
    '{16'h0000, 32767}, '{16'h7FFF, -1}, '{16'h8000, -1}, '{16'h0001, -1},
    '{16'hFFFF, -1}, '{16'h0000, -1}, '{16'h4000, -1}, '{16'hC000, -1},
    '{16'h5555, -1}, '{16'hAAAA, -1}, '{16'h7FFF, -1}, '{16'h8000, -1}};

  initial begin
    logic [31:0] v;
    logic signed [15:0] r;
    src_idle = 25; snk_idle = 62;
    rst = 1; s_axis_tvalid = 0; s_axis_tdata = 0; cfg_valid = 0;
    cfg_index = 0; cfg_data = 0;
    m_step = 0; m_scale = 256; m_adj = 0; m_kp = 0; m_ki = 0;
    m_nco = 0; m_est = 0; m_integ = 0; m_fbc = SMAX; m_fbs = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: reset gains first, zero mix gives cos(0)
    foreach (rows[i]) begin
      if (rows[i].known >= 0) begin
        advance_loop(rows[i].smp, r);
        if (r !== rows[i].known[15:0]) begin
          $error("directed row %0d expected %0d model %0d", i, rows[i].known, r);
          errors++;
        end
        m_nco = 0; m_est = 0; m_integ = 0; m_fbc = SMAX; m_fbs = 0;
      end
      send_sample(rows[i].smp);
      if (i == 5) begin
        wait_drained();
        write_reg(REG_PHASE_STEP, 32'h0CCC_CCCD);
        write_reg(REG_KP_GAIN, 32'h00FF_FFFF);
        write_reg(REG_KI_GAIN, 32'h00FF_FFFF);
        write_reg(REG_NCO_SCALE, 32'h0000_FFFF);
        write_reg(REG_PHASE_ADJUST, 32'hFFFF_FFFF);
        write_reg(3'd7, 32'hDEAD_BEEF);
      end
    end
    wait_drained();

    // random phases: settings vary, samples mostly tone-like
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin src_idle = 62; snk_idle = 25; end
      if (ph == 6) begin src_idle = 0; snk_idle = 0; end
      write_reg(REG_PHASE_STEP, (ph == 0) ? 32'hFFFF_FFFF : $urandom);
      write_reg(REG_NCO_SCALE, (ph == 1) ? 32'h0 : ((ph == 2) ? 32'h200 : $urandom));
      write_reg(REG_PHASE_ADJUST, (ph == 4) ? 32'h0 : $urandom);
      write_reg(REG_KP_GAIN, (ph == 5) ? 32'h0 : $urandom);
      write_reg(REG_KI_GAIN, (ph == 7) ? 32'hFFFF_FFFF : $urandom_range(32'h3FFFF));
      write_reg(CFG_IDX_W'($urandom_range(7)), $urandom);
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(3) == 0) v = $urandom;
        else if ($urandom_range(1)) v = n[0] ? 32'h7FFF : 32'h8000;
        else v = (n % 4 < 2) ? $urandom_range(32767) : -$urandom_range(32768);
        send_sample(v[15:0]);
        if (n == 25) wait_drained();
      end
      wait_drained();
    end

    repeat (DRAIN) @(negedge clk);
    if (errors == 0 && nco_expected.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ptpn_pkg.sv
hw/rtl/ptpn_cordic.sv
hw/rtl/pilot_tone_pll_nco_core.sv
hw/rtl/ptpn_checker.sv
tb/pilot_tone_pll_nco_core_tb.sv
